/* hdl/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// No dependencies; the using module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define E13D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define E13D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/e13d_pkg.sv */
// Shared types, code tables and constants for the EAN-13 symbol decoder.
// No dependencies.
package e13d_pkg;

  localparam int unsigned SYM_W    = 7;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned HALF_LEN = 6;
  localparam int unsigned NUM_DIGITS = 10;

  localparam logic [POS_W-1:0] HALF_POS = POS_W'(HALF_LEN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(11);
  localparam logic [POS_W-1:0] CODE_LEN = POS_W'(12);
  localparam logic [DIGIT_W-1:0] MAX_DIGIT = DIGIT_W'(9);

  typedef logic [SYM_W-1:0] sym_t;

  // L (odd parity), G (even parity) and R code sets, dark module = 1, first module MSB
  localparam sym_t SET_L [NUM_DIGITS] = '{
    7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
  };
  localparam sym_t SET_G [NUM_DIGITS] = '{
    7'h27, 7'h33, 7'h1B, 7'h21, 7'h1D, 7'h39, 7'h05, 7'h11, 7'h09, 7'h17
  };
  localparam sym_t SET_R [NUM_DIGITS] = '{
    7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
  };

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [HALF_LEN-1:0] parity;
    logic failed;
  } code_state_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic digit_ok;
    logic from_g_set;
    logic [POS_W-1:0] position;
    logic code_failed;
    logic [HALF_LEN-1:0] parity_pattern;
    logic last;
  } dec_result_t;

endpackage

/* hdl/e13d_match.sv */
// Combinational symbol match and code-state update for one symbol.
// Depends on e13d_pkg.
module e13d_match
  import e13d_pkg::*;
(
  input  sym_t        symbol,
  input  logic        restart,
  input  code_state_t state_cur,
  output code_state_t state_nxt,
  output dec_result_t result
);

  logic [POS_W-1:0]    pos;
  logic [HALF_LEN-1:0] par_base;
  logic                fail_base;
  logic                wrap;
  logic                left_half;
  logic                l_hit, g_hit, r_hit;
  logic [DIGIT_W-1:0]  l_dig, g_dig, r_dig;
  logic                hit, use_g, fail_new, ok, is_last;
  logic [DIGIT_W-1:0]  dig;
  logic [HALF_LEN-1:0] par_new;

  // table compares are independent; descending loop keeps the lowest digit
  always_comb begin
    l_hit = 1'b0;
    g_hit = 1'b0;
    r_hit = 1'b0;
    l_dig = '0;
    g_dig = '0;
    r_dig = '0;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      if (symbol == SET_L[i]) begin
        l_hit = 1'b1;
        l_dig = DIGIT_W'(i);
      end
      if (symbol == SET_G[i]) begin
        g_hit = 1'b1;
        g_dig = DIGIT_W'(i);
      end
      if (symbol == SET_R[i]) begin
        r_hit = 1'b1;
        r_dig = DIGIT_W'(i);
      end
    end
  end

  always_comb begin
    wrap      = restart || (state_cur.position >= CODE_LEN);
    pos       = wrap ? '0 : state_cur.position;
    par_base  = wrap ? '0 : state_cur.parity;
    fail_base = wrap ? 1'b0 : state_cur.failed;
    left_half = pos < HALF_POS;

    if (left_half) begin
      hit   = l_hit || g_hit;
      use_g = !l_hit && g_hit;
      dig   = l_hit ? l_dig : g_dig;
    end else begin
      hit   = r_hit;
      use_g = 1'b0;
      dig   = r_dig;
    end

    fail_new = fail_base || !hit;
    ok       = hit && !fail_new;
    is_last  = pos == LAST_POS;

    // symbol 0 lands in the MSB of the parity pattern
    par_new = par_base;
    if (ok && use_g) begin
      par_new = par_base | (HALF_LEN'(1 << (HALF_LEN - 1)) >> pos[2:0]);
    end

    result.digit          = ok ? dig : '0;
    result.digit_ok       = ok;
    result.from_g_set     = ok && use_g;
    result.position       = pos;
    result.code_failed    = fail_new;
    result.parity_pattern = par_new;
    result.last           = is_last;

    if (is_last) begin
      state_nxt = '0;
    end else begin
      state_nxt.position = pos + POS_W'(1);
      state_nxt.parity   = par_new;
      state_nxt.failed   = fail_new;
    end
  end

endmodule

/* hdl/ean13_symbol_decoder.sv */
// Top level of the EAN-13 symbol decoder: code state, result register and skid entry.
// Depends on e13d_pkg, e13d_match and assert_macros.svh.
//
// Takes one 7-module symbol per transfer and returns one decoded result per
// symbol, in order. A new symbol can be taken every cycle while in_stall
// is low. The table match and state update sit between the input
// handshake and a result register; a one-entry skid behind that register
// lets one more symbol be taken while a result waits, so in_stall is a
// register output and rises only once two results are held. Position,
// parity pattern and the sticky failure flag advance on each input transfer;
// restart, or the end of a twelve-symbol code, begins a new code.
`include "assert_macros.svh"

module ean13_symbol_decoder
  import e13d_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SYM_W-1:0]    in_symbol,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DIGIT_W-1:0]  out_digit,
  output logic                out_digit_ok,
  output logic                out_from_g_set,
  output logic [POS_W-1:0]    out_position,
  output logic                out_code_failed,
  output logic [HALF_LEN-1:0] out_parity_pattern,
  output logic                out_last
);

  code_state_t state_r, state_nxt;
  dec_result_t dec_res;
  dec_result_t out_res_r, skid_res_r;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        in_xfer, out_xfer;
  logic        load_out, load_skid, move_skid;

  e13d_match u_match (
    .symbol    (in_symbol),
    .restart   (in_restart),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (dec_res)
  );

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  assign out_xfer = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    move_skid      = 1'b0;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
      if (skid_valid_r) begin
        move_skid      = 1'b1;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end
    if (in_xfer) begin
      if (!out_valid_nxt) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (in_xfer) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      out_res_r <= skid_res_r;
    end else if (load_out) begin
      out_res_r <= dec_res;
    end
    if (load_skid) begin
      skid_res_r <= dec_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit          = out_res_r.digit;
  assign out_digit_ok       = out_res_r.digit_ok;
  assign out_from_g_set     = out_res_r.from_g_set;
  assign out_position       = out_res_r.position;
  assign out_code_failed    = out_res_r.code_failed;
  assign out_parity_pattern = out_res_r.parity_pattern;
  assign out_last           = out_res_r.last;

  `E13D_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with empty result register")
  `E13D_ASSERT_IMP(a_bad_digit_zero, out_valid_r && !out_res_r.digit_ok, out_res_r.digit == '0 && !out_res_r.from_g_set, "invalid digit not cleared")
  `E13D_ASSERT_IMP(a_ok_not_failed, out_valid_r && out_res_r.digit_ok, !out_res_r.code_failed && out_res_r.digit <= MAX_DIGIT, "valid digit in failed code")
  `E13D_ASSERT_IMP(a_last_position, out_valid_r, out_res_r.last == (out_res_r.position == LAST_POS), "last flag off position eleven")

endmodule

/* tb/sv/tb_ean13_symbol_decoder.sv */
// Self-checking testbench for ean13_symbol_decoder: directed codes, then random codes.
// Depends on e13d_pkg (types, widths) and the decoder RTL; the predictor keeps its own tables.
`timescale 1ns / 100ps

module tb_ean13_symbol_decoder;
  import e13d_pkg::*;

  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned MAX_IDLE    = 13;
  localparam int unsigned LONG_HOLD   = 120;
  localparam int unsigned HOLD_AFTER  = 400;

  typedef enum logic [1:0] {ODD_SET, EVEN_SET, RIGHT_SET} code_set_t;

  typedef struct {
    sym_t symbol;
    logic restart;
    int   gap;
    bit   drain;
  } sym_xfer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SYM_W-1:0]    in_symbol = '0;
  logic                in_restart = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DIGIT_W-1:0]  out_digit;
  logic                out_digit_ok;
  logic                out_from_g_set;
  logic [POS_W-1:0]    out_position;
  logic                out_code_failed;
  logic [HALF_LEN-1:0] out_parity_pattern;
  logic                out_last;

  ean13_symbol_decoder DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_symbol          (in_symbol),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit          (out_digit),
    .out_digit_ok       (out_digit_ok),
    .out_from_g_set     (out_from_g_set),
    .out_position       (out_position),
    .out_code_failed    (out_code_failed),
    .out_parity_pattern (out_parity_pattern),
    .out_last           (out_last)
  );

  // Module patterns, first module in bit 6, dark = 1
  localparam logic [6:0] ODD_TBL [10] = '{
    7'b0001101, 7'b0011001, 7'b0010011, 7'b0111101, 7'b0100011,
    7'b0110001, 7'b0101111, 7'b0111011, 7'b0110111, 7'b0001011
  };
  localparam logic [6:0] EVEN_TBL [10] = '{
    7'b0100111, 7'b0110011, 7'b0011011, 7'b0100001, 7'b0011101,
    7'b0111001, 7'b0000101, 7'b0010001, 7'b0001001, 7'b0010111
  };
  localparam logic [6:0] RIGHT_TBL [10] = '{
    7'b1110010, 7'b1100110, 7'b1101100, 7'b1000010, 7'b1011100,
    7'b1001110, 7'b1010000, 7'b1000100, 7'b1001000, 7'b1110100
  };

  // Predictor state
  logic [3:0] code_pos    = '0;
  logic [5:0] code_parity = '0;
  logic       code_fail   = 1'b0;

  sym_xfer_t   pending_syms[$];
  dec_result_t expected_digits[$];

  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned items_made = 0;
  bit          in_took = 1'b0;
  bit          out_took = 1'b0;
  bit          tx_fast = 1'b0;
  bit          drain_next = 1'b0;

  function automatic sym_t pattern_of(input code_set_t s, input int d);
    case (s)
      ODD_SET:  return ODD_TBL[d];
      EVEN_SET: return EVEN_TBL[d];
      default:  return RIGHT_TBL[d];
    endcase
  endfunction

  // Digit whose pattern equals sym, or 10 when the set has none
  function automatic int find_digit(input code_set_t s, input sym_t sym);
    for (int d = 0; d < 10; d++) begin
      if (pattern_of(s, d) == sym) return d;
    end
    return 10;
  endfunction

  function automatic dec_result_t decode_symbol(input sym_t sym, input logic restart);
    dec_result_t r;
    int          d;
    logic        g;
    logic        ok;
    g = 1'b0;
    if (restart || code_pos >= 4'd12) begin
      code_pos    = '0;
      code_parity = '0;
      code_fail   = 1'b0;
    end
    if (code_pos < 4'd6) begin
      d = find_digit(ODD_SET, sym);
      if (d > 9) begin
        d = find_digit(EVEN_SET, sym);
        g = (d <= 9);
      end
    end else begin
      d = find_digit(RIGHT_SET, sym);
    end
    if (d > 9) code_fail = 1'b1;
    ok = (d <= 9) && !code_fail;
    if (!ok) begin
      d = 0;
      g = 1'b0;
    end
    if (g) code_parity[5 - code_pos] = 1'b1;
    r.digit          = 4'(d);
    r.digit_ok       = ok;
    r.from_g_set     = g;
    r.position       = code_pos;
    r.code_failed    = code_fail;
    r.parity_pattern = code_parity;
    r.last           = (code_pos == 4'd11);
    if (r.last) begin
      code_pos    = '0;
      code_parity = '0;
      code_fail   = 1'b0;
    end else begin
      code_pos = code_pos + 4'd1;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  task automatic add_item(input sym_t sym, input logic restart);
    sym_xfer_t it;
    it.symbol  = sym;
    it.restart = restart;
    it.gap     = tx_fast ? 0 : $urandom_range(0, MAX_IDLE);
    it.drain   = drain_next;
    drain_next = 1'b0;
    pending_syms.push_back(it);
    items_made++;
  endtask

  // One code, mostly well formed; returns whether it was cut short
  task automatic add_code(input bit force_restart, output bit cut_short);
    sym_t syms[12];
    int   len;
    int   kind;
    int   bad_pos;
    bit   rs;
    kind    = $urandom_range(0, 9);
    tx_fast = ($urandom_range(0, 3) == 0);
    len     = 12;
    bad_pos = $urandom_range(0, 11);
    for (int i = 0; i < 12; i++) begin
      if (i < 6) syms[i] = pattern_of($urandom_range(0, 1) ? ODD_SET : EVEN_SET,
                                      $urandom_range(0, 9));
      else       syms[i] = pattern_of(RIGHT_SET, $urandom_range(0, 9));
    end
    case (kind)
      0: begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < 12; i++) syms[i] = sym_t'($urandom_range(0, 127));
      end
      1: syms[bad_pos] = syms[bad_pos] ^ sym_t'(1 << $urandom_range(0, 6));
      2: begin
        // pattern from the wrong half
        if (bad_pos < 6) syms[bad_pos] = pattern_of(RIGHT_SET, $urandom_range(0, 9));
        else syms[bad_pos] = pattern_of($urandom_range(0, 1) ? ODD_SET : EVEN_SET,
                                        $urandom_range(0, 9));
      end
      3: len = $urandom_range(1, 11);
      default: ;
    endcase
    rs = force_restart || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      add_item(syms[i], (i == 0) ? rs : (kind == 0 && $urandom_range(0, 7) == 0));
    end
    cut_short = (len < 12);
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Monitor and predictor hookup; results checked before this edge's input is predicted
  always @(posedge clk) begin
    dec_result_t exp_r;
    cycle_cnt++;
    in_took  = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;
    if (out_took) begin
      results_seen++;
      if (expected_digits.size() == 0) begin
        $error("result transfer with no expected result pending");
        err_cnt++;
      end else begin
        exp_r = expected_digits.pop_front();
        check_field("digit", exp_r.digit, out_digit);
        check_field("digit_ok", exp_r.digit_ok, out_digit_ok);
        check_field("from_g_set", exp_r.from_g_set, out_from_g_set);
        check_field("position", exp_r.position, out_position);
        check_field("code_failed", exp_r.code_failed, out_code_failed);
        check_field("parity_pattern", exp_r.parity_pattern, out_parity_pattern);
        check_field("last", exp_r.last, out_last);
      end
    end
    if (in_took) expected_digits.push_back(decode_symbol(in_symbol, in_restart));
  end

  // Driver
  always @(negedge clk) begin
    sym_xfer_t nxt;
    logic      nv;
    int        gap_cnt;
    nv = in_valid;
    if (in_took) nv = 1'b0;
    if (rst_n && !nv && pending_syms.size() > 0) begin
      if (pending_syms[0].drain && expected_digits.size() > 0) begin
        // hold until the block has drained
      end else if (gap_cnt < pending_syms[0].gap) begin
        gap_cnt++;
      end else begin
        nxt = pending_syms.pop_front();
        gap_cnt = 0;
        nv = 1'b1;
        in_symbol  <= nxt.symbol;
        in_restart <= nxt.restart;
      end
    end
    in_valid <= nv;
  end

  // Receiver: per-result wait, plus one long hold-off to back up the input
  always @(negedge clk) begin
    int unsigned rx_wait;
    int unsigned rx_hold;
    bit          rx_fast;
    bit          hold_done;
    logic        st;
    if (out_took) begin
      if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
      rx_wait = rx_fast ? 0 : $urandom_range(0, MAX_IDLE);
    end
    if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      rx_hold = LONG_HOLD;
    end
    st = 1'b0;
    if (rx_hold > 0) begin
      rx_hold--;
      st = 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      st = 1'b1;
    end
    out_stall <= rst_n ? st : 1'b0;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAIL ean13_symbol_decoder");
    $finish;
  end

  initial begin
    bit cut;
    bit force_rs;
    // Directed: digits of every set, wrap without restart, no-match extremes,
    // symbols after a failure, restart in mid-code
    add_item(pattern_of(ODD_SET, 0), 1'b1);
    add_item(pattern_of(EVEN_SET, 1), 1'b0);
    add_item(pattern_of(ODD_SET, 2), 1'b0);
    add_item(pattern_of(EVEN_SET, 3), 1'b0);
    add_item(pattern_of(ODD_SET, 4), 1'b0);
    add_item(pattern_of(EVEN_SET, 5), 1'b0);
    for (int d = 6; d < 12; d++) add_item(pattern_of(RIGHT_SET, d % 10), 1'b0);
    add_item(pattern_of(EVEN_SET, 6), 1'b0);
    add_item(pattern_of(ODD_SET, 7), 1'b0);
    add_item(pattern_of(EVEN_SET, 8), 1'b0);
    add_item(pattern_of(ODD_SET, 9), 1'b0);
    add_item(7'h7F, 1'b0);
    add_item(pattern_of(EVEN_SET, 0), 1'b0);
    add_item(pattern_of(RIGHT_SET, 2), 1'b0);
    add_item(pattern_of(RIGHT_SET, 3), 1'b0);
    add_item(7'h00, 1'b0);
    add_item(pattern_of(EVEN_SET, 9), 1'b1);
    add_item(pattern_of(ODD_SET, 5), 1'b0);
    for (int d = 0; d < 10; d++) add_item(pattern_of(ODD_SET, d), 1'b0);
    for (int d = 0; d < 10; d++) add_item(pattern_of(RIGHT_SET, d), 1'b0);

    drain_next = 1'b1;
    force_rs = 1'b1;
    for (int n = 0; items_made < ITEM_TARGET; n++) begin
      if (n % 40 == 39) drain_next = 1'b1;
      add_code(force_rs, cut);
      force_rs = cut && ($urandom_range(0, 3) != 0);
    end

    wait (rst_n);
    wait (pending_syms.size() == 0 && !in_valid);
    wait (expected_digits.size() == 0);
    repeat (20) @(posedge clk);
    if (expected_digits.size() != 0) begin
      $error("%0d expected results never arrived", expected_digits.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS ean13_symbol_decoder");
    end else begin
      $display("FAIL ean13_symbol_decoder");
    end
    $finish;
  end

endmodule
